/* rtl/tat_pkg.sv */
// shared constants and types for the thermistor temperature converter
`default_nettype none

package tat_pkg;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERIES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY   = 3'd4;

    localparam int COEFF_W  = 48;
    localparam int SER_W    = 20;
    localparam int SUP_W    = 16;
    localparam int MV_W     = 16;
    localparam int TEMP_W   = 20;

    localparam logic [COEFF_W-1:0] RST_COEFF_A = 48'd79228162514264;
    localparam logic [COEFF_W-1:0] RST_COEFF_B = 48'd17293822569102;
    localparam logic [COEFF_W-1:0] RST_COEFF_C = 48'd7205759403;
    localparam logic [SER_W-1:0]   RST_SERIES  = 20'd10000;
    localparam logic [SUP_W-1:0]   RST_SUPPLY  = 16'd5000;

    // log2 fraction bits and ln(2) in q.32
    localparam int          LOG_FRAC = 24;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;

    // quotient bits kept from 2^64 / d
    localparam int           DIV_BITS   = 21;
    localparam logic [20:0]  KELVIN_Q8  = 21'd69926;
    localparam logic [20:0]  KELVIN_MAX = 21'd594213;
    localparam logic [TEMP_W-1:0] TEMP_MAX = 20'd524287;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_OPEN  = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

endpackage

`default_nettype wire

/* rtl/tat_if.sv */
// stream and configuration channels of the thermistor temperature converter
`default_nettype none

interface tat_in_if #(parameter int ADC_BITS = 10);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_code;
    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

interface tat_out_if;
    import tat_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [MV_W-1:0]          divider_millivolts;
    logic signed [TEMP_W-1:0] temp_celsius_q8;
    logic [1:0]               status;
    modport source (output valid, output divider_millivolts, output temp_celsius_q8,
                    output status, input ready);
    modport sink   (input valid, input divider_millivolts, input temp_celsius_q8,
                    input status, output ready);
endinterface

interface tat_cfg_if;
    import tat_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/tat_log2.sv */
// pipelined log2 in q.24: leading one, normalize, then one squaring per stage
`default_nettype none

module tat_log2 #(
    parameter int W = 36
) (
    input  wire logic                                   i_clk,
    input  wire logic [tat_pkg::LOG_FRAC+1:0]           i_en,
    input  wire logic [W-1:0]                           i_x,
    output logic      [$clog2(W)+tat_pkg::LOG_FRAC-1:0] o_log
);
    import tat_pkg::*;

    localparam int KW = $clog2(W);

    logic [W-1:0]  r_x0;
    logic [KW-1:0] r_k0;
    logic [KW-1:0] n_k0;
    logic [63:0]   n_ext;

    logic [31:0]         r_m  [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] r_fr [0:LOG_FRAC];
    logic [KW-1:0]       r_kk [0:LOG_FRAC];

    // leading one position
    always_comb begin
        n_k0 = '0;
        for (int i = 0; i < W; i++) begin
            if (i_x[i]) begin
                n_k0 = KW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x0 <= i_x;
            r_k0 <= n_k0;
        end
    end

    // msb to bit 63, mantissa is the top word
    assign n_ext = 64'(r_x0) << (6'd63 - 6'(r_k0));

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_m[0]  <= n_ext[63:32];
            r_fr[0] <= '0;
            r_kk[0] <= r_k0;
        end
    end

    for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
        logic [63:0] n_p;
        logic [32:0] n_t;
        assign n_p = 64'(r_m[g]) * 64'(r_m[g]);
        assign n_t = n_p[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en[g+2]) begin
                r_m[g+1]  <= n_t[32] ? n_t[32:1] : n_t[31:0];
                r_fr[g+1] <= {r_fr[g][LOG_FRAC-2:0], n_t[32]};
                r_kk[g+1] <= r_kk[g];
            end
        end
    end

    assign o_log = {r_kk[LOG_FRAC], r_fr[LOG_FRAC]};

endmodule

`default_nettype wire

/* rtl/thermistor_adc_to_temperature.sv */
// top level: thermistor divider code to millivolts and steinhart-hart temperature
//
// channels: i_sample carries one adc_code per transaction, o_result returns one
// transaction per sample with divider_millivolts, temp_celsius_q8 (1/256 degree)
// and status (valid, open circuit, saturated). i_cfg writes the five registers
// by index (coefficients a, b, c, series ohms, supply millivolts); it is always
// ready and is meant to be written only while no sample is in flight.
// depth: 57 register stages, from the stage that accepts a sample to the output
// register on o_result; the length comes from the 24 squaring stages of each
// log2 unit and the 21 compare-subtract stages that form 2^64 / d, one quotient
// bit per stage.
// throughput: one sample per cycle while the pipe is not stalled. every stage has a
// valid bit and its own load enable, so bubbles close up: the input keeps taking
// samples while a result waits on o_result, until every stage holds an item.
// when the receiver stalls, items stay in place and none is dropped or repeated.
// reset clears all valid bits and loads the register defaults; payload
// registers are not reset.
`default_nettype none

module thermistor_adc_to_temperature #(
    parameter int ADC_BITS = 10
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tat_cfg_if.sink    i_cfg,
    tat_in_if.sink     i_sample,
    tat_out_if.source  o_result
);
    import tat_pkg::*;

    // numerator series * (2^n - code) stays below 2^(20 + n)
    localparam int NUM_W   = SER_W + ADC_BITS;
    localparam int NKW     = $clog2(NUM_W);
    localparam int CKW     = $clog2(ADC_BITS);
    localparam int LGW     = NKW + LOG_FRAC;
    localparam int L2W     = 2 * LGW - LOG_FRAC;
    localparam int L3W     = L2W + LGW - LOG_FRAC;
    localparam int HALF_W  = COEFF_W / 2;
    localparam int LOG_STG = LOG_FRAC + 2;

    // stage map
    localparam int ST_LG   = LOG_STG + 1;
    localparam int ST_M1   = ST_LG + 1;
    localparam int ST_M2   = ST_M1 + 1;
    localparam int ST_M3   = ST_M2 + 1;
    localparam int ST_M4   = ST_M3 + 1;
    localparam int ST_M5   = ST_M4 + 1;
    localparam int ST_M6   = ST_M5 + 1;
    localparam int ST_D0   = ST_M6 + 1;
    localparam int ST_OUT  = ST_D0 + DIV_BITS + 1;
    localparam int NS      = ST_OUT + 1;

    localparam logic [ADC_BITS:0] FULL      = {1'b1, {ADC_BITS{1'b0}}};
    localparam logic [63:0]       DIV_START = 64'd1 << (64 - DIV_BITS);

    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic            zero;
        logic            ser0;
    } t_side;

    // configuration registers
    logic [COEFF_W-1:0] r_coeff_a, r_coeff_b, r_coeff_c;
    logic [SER_W-1:0]   r_series;
    logic [SUP_W-1:0]   r_supply;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_a <= RST_COEFF_A;
            r_coeff_b <= RST_COEFF_B;
            r_coeff_c <= RST_COEFF_C;
            r_series  <= RST_SERIES;
            r_supply  <= RST_SUPPLY;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_COEFF_A: r_coeff_a <= i_cfg.data;
                REG_COEFF_B: r_coeff_b <= i_cfg.data;
                REG_COEFF_C: r_coeff_c <= i_cfg.data;
                REG_SERIES:  r_series  <= i_cfg.data[SER_W-1:0];
                REG_SUPPLY:  r_supply  <= i_cfg.data[SUP_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficient magnitudes and signs, to be kept static by the user while items flow (not enforced)
    logic [COEFF_W-1:0] n_bmag, n_cmag;
    logic               n_bneg, n_cneg;
    assign n_bneg = r_coeff_b[COEFF_W-1];
    assign n_cneg = r_coeff_c[COEFF_W-1];
    assign n_bmag = n_bneg ? (~r_coeff_b + 1'b1) : r_coeff_b;
    assign n_cmag = n_cneg ? (~r_coeff_c + 1'b1) : r_coeff_c;

    // valid bits and per-stage load enables
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_en;

    always_comb begin
        n_en[NS-1] = !r_vld[NS-1] || o_result.ready;
        for (int s = NS - 2; s >= 0; s--) begin
            n_en[s] = !r_vld[s] || n_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (n_en[s]) begin
                    r_vld[s] <= (s == 0) ? i_sample.valid : r_vld[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    assign i_sample.ready = n_en[0];

    // stage 0: divider numerator and millivolts
    logic [ADC_BITS:0]           n_span;
    logic [SER_W+ADC_BITS:0]     n_prod;
    logic [ADC_BITS+SUP_W-1:0]   n_mvp;
    logic [NUM_W-1:0]            r_num;
    logic [ADC_BITS-1:0]         r_code;
    t_side                       r_side [0:ST_OUT-1];

    assign n_span = FULL - {1'b0, i_sample.adc_code};
    assign n_prod = r_series * n_span;
    assign n_mvp  = i_sample.adc_code * r_supply;

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_code         <= i_sample.adc_code;
            r_num          <= n_prod[NUM_W-1:0];
            r_side[0].mv   <= n_mvp[ADC_BITS+SUP_W-1:ADC_BITS];
            r_side[0].zero <= (i_sample.adc_code == '0);
            r_side[0].ser0 <= (r_series == '0);
        end
    end

    for (genvar s = 1; s < ST_OUT; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (n_en[s]) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // two log2 units side by side
    logic [LGW-1:0]          n_logn;
    logic [CKW+LOG_FRAC-1:0] n_logc;

    tat_log2 #(.W(NUM_W)) u_log_num (
        .i_clk (i_clk),
        .i_en  (n_en[LOG_STG:1]),
        .i_x   (r_num),
        .o_log (n_logn)
    );

    tat_log2 #(.W(ADC_BITS)) u_log_code (
        .i_clk (i_clk),
        .i_en  (n_en[LOG_STG:1]),
        .i_x   (r_code),
        .o_log (n_logc)
    );

    // log difference as sign and magnitude
    logic [LGW-1:0] n_logc_x;
    logic [LGW-1:0] r_lgmag;
    logic           r_lgneg;
    assign n_logc_x = LGW'(n_logc);

    always_ff @(posedge i_clk) begin
        if (n_en[ST_LG]) begin
            r_lgneg <= (n_logn < n_logc_x);
            r_lgmag <= (n_logn < n_logc_x) ? (n_logc_x - n_logn) : (n_logn - n_logc_x);
        end
    end

    // ln r = log2 r * ln 2
    logic [LGW+31:0] n_lnp;
    logic [LGW-1:0]  r_lm;
    logic            r_lneg;
    assign n_lnp = r_lgmag * LN2_Q32;

    always_ff @(posedge i_clk) begin
        if (n_en[ST_M1]) begin
            r_lm   <= n_lnp[LGW+31:32];
            r_lneg <= r_lgneg;
        end
    end

    // ln^2 and the two halves of b * ln
    logic [2*LGW-1:0]        n_l2p;
    logic [L2W-1:0]          r_l2;
    logic [HALF_W+LGW-1:0]   r_bh, r_bl;
    logic [LGW-1:0]          r_lm2;
    logic                    r_lneg2;
    assign n_l2p = r_lm * r_lm;

    always_ff @(posedge i_clk) begin
        if (n_en[ST_M2]) begin
            r_l2    <= n_l2p[2*LGW-1:LOG_FRAC];
            r_bh    <= n_bmag[COEFF_W-1:HALF_W] * r_lm;
            r_bl    <= n_bmag[HALF_W-1:0] * r_lm;
            r_lm2   <= r_lm;
            r_lneg2 <= r_lneg;
        end
    end

    // ln^3 and b term magnitude
    logic [L2W+LGW-1:0] n_l3p;
    logic [L3W-1:0]     r_l3;
    logic [63:0]        r_tbm;
    logic               r_tbneg, r_lneg3;
    assign n_l3p = r_l2 * r_lm2;

    always_ff @(posedge i_clk) begin
        if (n_en[ST_M3]) begin
            r_l3    <= n_l3p[L2W+LGW-1:LOG_FRAC];
            r_tbm   <= 64'(r_bh) + 64'(r_bl[HALF_W+LGW-1:LOG_FRAC]);
            r_tbneg <= n_bneg ^ r_lneg2;
            r_lneg3 <= r_lneg2;
        end
    end

    // two halves of c * ln^3
    logic [HALF_W+L3W-1:0] r_ch, r_cl;
    logic [63:0]           r_tbm4;
    logic                  r_tbneg4, r_tcneg4;

    always_ff @(posedge i_clk) begin
        if (n_en[ST_M4]) begin
            r_ch     <= n_cmag[COEFF_W-1:HALF_W] * r_l3;
            r_cl     <= n_cmag[HALF_W-1:0] * r_l3;
            r_tbm4   <= r_tbm;
            r_tbneg4 <= r_tbneg;
            r_tcneg4 <= n_cneg ^ r_lneg3;
        end
    end

    // signed b and c terms, truncated toward zero
    logic [63:0] n_tcm;
    logic [63:0] r_tb, r_tc;
    assign n_tcm = 64'(r_ch) + 64'(r_cl[HALF_W+L3W-1:LOG_FRAC]);

    always_ff @(posedge i_clk) begin
        if (n_en[ST_M5]) begin
            r_tb <= r_tbneg4 ? (~r_tbm4 + 64'd1) : r_tbm4;
            r_tc <= r_tcneg4 ? (~n_tcm + 64'd1) : n_tcm;
        end
    end

    // denominator d = a + b ln + c ln^3 in scale 2^-56
    logic [63:0] r_d;

    always_ff @(posedge i_clk) begin
        if (n_en[ST_M6]) begin
            r_d <= {{(64-COEFF_W){r_coeff_a[COEFF_W-1]}}, r_coeff_a} + r_tb + r_tc;
        end
    end

    // 2^64 / d, one quotient bit per stage; small or non-positive d saturates
    logic [63:0]         r_rem  [0:DIV_BITS];
    logic [62:0]         r_ud   [0:DIV_BITS];
    logic [DIV_BITS-1:0] r_q    [0:DIV_BITS];
    logic                r_dsat [0:DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (n_en[ST_D0]) begin
            r_dsat[0] <= r_d[63] || (r_d[62:0] <= DIV_START[62:0]);
            r_ud[0]   <= r_d[62:0];
            r_rem[0]  <= DIV_START;
            r_q[0]    <= '0;
        end
    end

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
        logic [63:0] n_t;
        logic        n_ge;
        assign n_t  = {r_rem[g][62:0], 1'b0};
        assign n_ge = (n_t >= {1'b0, r_ud[g]});
        always_ff @(posedge i_clk) begin
            if (n_en[ST_D0+g+1]) begin
                r_rem[g+1]  <= n_ge ? (n_t - {1'b0, r_ud[g]}) : n_t;
                r_q[g+1]    <= {r_q[g][DIV_BITS-2:0], n_ge};
                r_ud[g+1]   <= r_ud[g];
                r_dsat[g+1] <= r_dsat[g];
            end
        end
    end

    // output register: kelvin to celsius and status
    t_side                    n_fs;
    logic [DIV_BITS-1:0]      n_q;
    logic [DIV_BITS-1:0]      n_cel;
    logic [MV_W-1:0]          r_out_mv;
    logic [TEMP_W-1:0]        r_out_temp;
    t_status                  r_out_status;

    assign n_fs  = r_side[ST_OUT-1];
    assign n_q   = r_q[DIV_BITS];
    assign n_cel = n_q - KELVIN_Q8;

    always_ff @(posedge i_clk) begin
        if (n_en[ST_OUT]) begin
            r_out_mv <= n_fs.mv;
            if (n_fs.zero) begin
                r_out_temp   <= '0;
                r_out_status <= ST_OPEN;
            end else if (n_fs.ser0 || r_dsat[DIV_BITS] || (n_q > KELVIN_MAX)) begin
                r_out_temp   <= TEMP_MAX;
                r_out_status <= ST_SAT;
            end else begin
                r_out_temp   <= n_cel[TEMP_W-1:0];
                r_out_status <= ST_VALID;
            end
        end
    end

    assign o_result.valid              = r_vld[NS-1];
    assign o_result.divider_millivolts = r_out_mv;
    assign o_result.temp_celsius_q8    = r_out_temp;
    assign o_result.status             = r_out_status;

endmodule

`default_nettype wire

/* bench/thermistor_adc_to_temperature_tb_if.sv */
// predicted result type for the thermistor converter bench; the channel interfaces come from the rtl interface file
`timescale 1ns / 1ps
package thermistor_adc_to_temperature_tb_pkg;
    import tat_pkg::*;

    // one predicted result transaction
    typedef struct {
        logic [MV_W-1:0]          mv;
        logic signed [TEMP_W-1:0] temp;
        t_status                  status;
    } t_reading;
endpackage

/* bench/thermistor_adc_to_temperature_tb.sv */
// self-checking bench for the thermistor code to temperature converter
`timescale 1ns / 1ps

module thermistor_adc_to_temperature_tb;
    import tat_pkg::*;
    import thermistor_adc_to_temperature_tb_pkg::*;

    localparam int  ADC_BITS  = 10;
    localparam int  LIMIT     = 400000;
    localparam int  DRAIN_CYC = 64;

    // steinhart-hart predictor plus the queue of readings still owed by the block
    class temp_scoreboard;
        logic [COEFF_W-1:0] coef_a, coef_b, coef_c;
        logic [SER_W-1:0]   series;
        logic [SUP_W-1:0]   supply;
        t_reading           owed[$];
        int                 errors, results, samples;

        function new();
            coef_a = RST_COEFF_A;
            coef_b = RST_COEFF_B;
            coef_c = RST_COEFF_C;
            series = RST_SERIES;
            supply = RST_SUPPLY;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_COEFF_A: coef_a = val;
                REG_COEFF_B: coef_b = val;
                REG_COEFF_C: coef_c = val;
                REG_SERIES:  series = val[SER_W-1:0];
                REG_SUPPLY:  supply = val[SUP_W-1:0];
                default: ;
            endcase
        endfunction

        // log2 in q.24 by repeated squaring of the normalized mantissa
        function longint log2_q24(longint unsigned x);
            int                   k;
            logic [63:0]          m, f;
            logic [127:0]         sq;
            k = 63;
            while (k > 0 && !x[k]) k--;
            m = (k >= 31) ? x >> (k - 31) : x << (31 - k);
            f = 0;
            for (int i = 0; i < LOG_FRAC; i++) begin
                sq = {64'd0, m} * {64'd0, m};
                m  = sq[94:31];
                f  = f << 1;
                if (m >= 64'h1_0000_0000) begin
                    m = m >> 1;
                    f = f | 1;
                end
            end
            return (longint'(k) << LOG_FRAC) | longint'(f);
        endfunction

        // exact product, magnitude shifted right, sign restored
        function longint mul_trunc(longint a, longint b, int s);
            logic signed [127:0] pa, pb, p;
            logic [127:0]        mag;
            logic [63:0]         r;
            logic                neg;
            pa  = a;
            pb  = b;
            p   = pa * pb;
            neg = p < 0;
            mag = neg ? -p : p;
            r   = mag >> s;
            r[63] = 1'b0;
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function t_reading convert(logic [ADC_BITS-1:0] code);
            t_reading     rd;
            longint       lg, l, l2, l3, d;
            logic [127:0] kq;
            logic [31:0]  mvp;
            mvp     = code * supply;
            rd.mv   = mvp[ADC_BITS +: MV_W];
            rd.temp = TEMP_MAX;
            rd.status = ST_SAT;
            if (code == 0) begin
                rd.temp   = 0;
                rd.status = ST_OPEN;
                return rd;
            end
            if (series == 0) return rd;
            lg = log2_q24(longint'(series) * (1024 - longint'(code))) - log2_q24(code);
            l  = mul_trunc(lg, longint'(LN2_Q32), 32);
            l2 = mul_trunc(l, l, LOG_FRAC);
            l3 = mul_trunc(l2, l, LOG_FRAC);
            d  = longint'(signed'(coef_a))
                 + mul_trunc(longint'(signed'(coef_b)), l, LOG_FRAC)
                 + mul_trunc(longint'(signed'(coef_c)), l3, LOG_FRAC);
            if (d <= 0) return rd;
            kq = (128'd1 << 64) / 128'(d);
            if (kq > KELVIN_MAX) return rd;
            rd.temp   = kq[TEMP_W-1:0] - KELVIN_Q8[TEMP_W-1:0];
            rd.status = ST_VALID;
            return rd;
        endfunction

        function void note_sample(logic [ADC_BITS-1:0] code);
            owed.push_back(convert(code));
            samples++;
        endfunction

        function void check_reading(logic [MV_W-1:0] mv, logic [TEMP_W-1:0] temp,
                                    logic [1:0] st);
            t_reading ex;
            results++;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result mv=%0d temp=%0d st=%0d",
                                           mv, signed'(temp), st);
                return;
            end
            ex = owed.pop_front();
            if (mv !== ex.mv || temp !== ex.temp || st !== ex.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp mv=%0d temp=%0d st=%0d, got mv=%0d temp=%0d st=%0d",
                             ex.mv, ex.temp, ex.status, mv, signed'(temp), st);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tat_cfg_if              cfg_ch();
    tat_in_if #(ADC_BITS)   smp_ch();
    tat_out_if              res_ch();

    thermistor_adc_to_temperature #(.ADC_BITS(ADC_BITS)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_sample (smp_ch),
        .o_result (res_ch)
    );

    temp_scoreboard sb = new();
    bit  send_idle = 1'b0;   // random gaps between samples
    bit  recv_idle = 1'b0;   // random stalls on the result side
    int  hold_len  = 0;      // one long result stall requested by the main flow
    int  cfg_writes = 0;
    int  cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        smp_ch.valid = 1'b0;
        smp_ch.adc_code = '0;
        res_ch.ready = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random stalls, an occasional long hold, check every transaction
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = recv_idle ? $urandom_range(0, 12) : 0;
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            sb.check_reading(res_ch.divider_millivolts, res_ch.temp_celsius_q8,
                             res_ch.status);
            @(negedge i_clk);
        end
    end

    // one sample transaction, entered and left at a falling edge
    task automatic send_code(logic [ADC_BITS-1:0] code);
        int gap;
        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            smp_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_ch.valid    = 1'b1;
        smp_ch.adc_code = code;
        do @(posedge i_clk); while (!smp_ch.ready);
        sb.note_sample(code);
        @(negedge i_clk);
    endtask

    // stop offering samples until every owed result is back
    task automatic drain();
        smp_ch.valid = 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_all(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                           logic [19:0] ser, logic [15:0] sup);
        drain();
        repeat (DRAIN_CYC) @(negedge i_clk);
        write_cfg(REG_COEFF_A, a);
        write_cfg(REG_COEFF_B, b);
        write_cfg(REG_COEFF_C, c);
        write_cfg(REG_SERIES, 48'(ser));
        write_cfg(REG_SUPPLY, 48'(sup));
    endtask

    // code extremes, single-bit and alternating-bit patterns
    task automatic directed_codes();
        send_code('0);
        send_code(10'd1);
        send_code(10'd2);
        send_code(10'd512);
        send_code(10'd511);
        send_code(10'd1022);
        send_code(10'd1023);
        send_code(10'h155);
        send_code(10'h2aa);
    endtask

    task automatic random_codes(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 40) == 0) send_idle = ~send_idle;
            send_code(10'($urandom_range(0, 1023)));
        end
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // coefficients near a sensible thermistor so most readings land in range
    function automatic logic [47:0] nudge(logic [47:0] base, int span);
        return base + 48'(signed'($urandom_range(0, 2 * span) - span)) * 48'd4096;
    endfunction

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset coefficients, no idling first
        directed_codes();
        random_codes(60);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        random_codes(60);

        // register extremes
        set_all(48'h7fff_ffff_ffff, 48'h8000_0000_0000, 48'd0, 20'hfffff, 16'hffff);
        directed_codes();
        set_all(48'h8000_0000_0000, 48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff, 20'd1, 16'd1);
        directed_codes();
        set_all(48'd0, 48'hffff_ffff_ffff, 48'h8000_0000_0000, 20'h55555, 16'haaaa);
        random_codes(15);

        // long result hold while samples keep coming, so the pipe backs up
        set_all(RST_COEFF_A, RST_COEFF_B, RST_COEFF_C, RST_SERIES, RST_SUPPLY);
        send_idle = 1'b0;
        hold_len  = 300;
        random_codes(100);
        send_idle = 1'b1;

        // several perturbed settings and one fully random setting
        for (int p = 0; p < 6; p++) begin
            set_all(nudge(RST_COEFF_A, 4000000), nudge(RST_COEFF_B, 400000),
                    nudge(RST_COEFF_C, 2000), 20'($urandom_range(1, 20'hfffff)),
                    16'($urandom_range(1, 16'hffff)));
            random_codes(30);
        end
        set_all(rand48(), rand48(), rand48(), 20'($urandom_range(1, 20'hfffff)),
                16'($urandom_range(1, 16'hffff)));
        random_codes(20);

        // writes past the last register must change nothing
        drain();
        repeat (DRAIN_CYC) @(negedge i_clk);
        write_cfg(3'd5, rand48());
        write_cfg(3'd6, rand48());
        write_cfg(3'd7, rand48());
        random_codes(25);

        drain();
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("covered %0d samples, %0d results checked, %0d register writes",
                 sb.samples, sb.results, cfg_writes);
        $display("settings ranged over reset, extreme, perturbed and random coefficients");
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tat_pkg.sv
rtl/tat_if.sv
rtl/tat_log2.sv
rtl/thermistor_adc_to_temperature.sv
bench/thermistor_adc_to_temperature_tb_if.sv
bench/thermistor_adc_to_temperature_tb.sv
